// ===== design/frame_part_reassembly_tracker_defines.svh =====
// Assertion macros shared by the checker of the frame part reassembly tracker.
// Included by the checker file; expects signals clk and rst in scope.
`ifndef FRAME_PART_REASSEMBLY_TRACKER_DEFINES_SVH
`define FRAME_PART_REASSEMBLY_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame part tracker check failed");

// Consequent must hold in the cycle after the antecedent.
`define FPRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame part tracker check failed");

`endif

// ===== design/frpt_pkg.sv =====
// Shared constants, types and helper functions of the frame part reassembly tracker.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package frpt_pkg;

  localparam int OPEN_FRAMES = 16;
  localparam int SLOT_W      = $clog2(OPEN_FRAMES);
  localparam int FILL_W      = $clog2(OPEN_FRAMES + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PARTS_PER_FRAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKETS_PER_PART = 2'd1;

  localparam logic [3:0]  PARTS_PER_FRAME_RST  = 4'd4;
  localparam logic [15:0] PACKETS_PER_PART_RST = 16'd256;
  localparam logic [3:0]  PARTS_MAX            = 4'd15;

  localparam logic [2:0] ST_REJECTED   = 3'd0;
  localparam logic [2:0] ST_OPENED     = 3'd1;
  localparam logic [2:0] ST_ADDED      = 3'd2;
  localparam logic [2:0] ST_COMPLETED  = 3'd3;
  localparam logic [2:0] ST_OPEN_EVICT = 3'd4;

  typedef struct packed {
    logic load;       // latch a new part and restart the scan
    logic step;       // advance the scan to the next slot
    logic do_reject;  // finish with a rejected result
    logic do_add;     // the scanned slot matches: add the part to it
    logic do_open;    // no slot matches: open a new one
  } dp_cmd_t;

  typedef struct packed {
    logic pkt_ok;
    logic hit;
    logic scan_end;
  } dp_status_t;

  // Ring position base + ofs, wrapped at the slot count; the sum stays below twice it.
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] base,
                                                  input logic [FILL_W-1:0] ofs);
    logic [FILL_W:0] sum;
    sum = {{(FILL_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, ofs};
    if (sum >= (FILL_W + 1)'(OPEN_FRAMES)) begin
      sum = sum - (FILL_W + 1)'(OPEN_FRAMES);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [4:0] purge_sat(input logic [FILL_W-1:0] cnt);
    logic [FILL_W+4:0] wide;
    wide = {5'b0, cnt};
    if (wide > (FILL_W + 5)'(31)) begin
      return 5'd31;
    end
    return wide[4:0];
  endfunction

endpackage

// ===== design/frpt_ctrl.sv =====
// Controller of the frame part reassembly tracker: sequences the slot scan.
// Depends on frpt_pkg for the command and status structs.
`timescale 1ns / 1ps

module frpt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  frpt_pkg::dp_status_t st,
  output frpt_pkg::dp_cmd_t    cmd
);
  import frpt_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            busy  <= 1'b1;
          end
        end
        S_SCAN: begin
          if (!st.pkt_ok || st.scan_end || st.hit) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.load = start;
      S_SCAN: begin
        if (!st.pkt_ok) begin
          cmd.do_reject = 1'b1;
        end else if (st.scan_end) begin
          cmd.do_open = 1'b1;
        end else if (st.hit) begin
          cmd.do_add = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/frpt_dp.sv =====
// Datapath of the frame part reassembly tracker: slot ring, origin time,
// configuration registers and result registers. Depends on frpt_pkg.
`timescale 1ns / 1ps

module frpt_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  frpt_pkg::dp_cmd_t                     cmd,
  output frpt_pkg::dp_status_t                  st,
  input  logic                                  cfg_valid,
  input  logic [frpt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                           cfg_data,
  input  logic [63:0]                           frame_index,
  input  logic [15:0]                           packet_count,
  input  logic [2:0]                            part_x,
  input  logic [2:0]                            part_y,
  input  logic [63:0]                           part_timestamp,
  output logic                                  done,
  output logic [2:0]                            status,
  output logic [63:0]                           done_index,
  output logic [4:0]                            purged_count,
  output logic [63:0]                           frame_time,
  output logic                                  frame_time_valid
);
  import frpt_pkg::*;

  logic [63:0] slot_index      [OPEN_FRAMES];
  logic [3:0]  slot_parts      [OPEN_FRAMES];
  logic [63:0] slot_time       [OPEN_FRAMES];
  logic        slot_time_valid [OPEN_FRAMES];

  logic [SLOT_W-1:0] ring_head;
  logic [FILL_W-1:0] ring_fill;
  logic [FILL_W-1:0] scan_k;
  logic [63:0]       origin_time;
  logic              origin_seen;
  logic [3:0]        parts_per_frame;
  logic [15:0]       packets_per_part;

  logic [63:0] idx_q;
  logic [15:0] pkts_q;
  logic        at_origin_q;
  logic [63:0] ts_q;

  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] open_slot;
  logic              ring_full;
  logic [63:0]       rel_time;
  logic [3:0]        parts_inc;
  logic              complete;
  logic [63:0]       add_time;
  logic              add_valid;
  logic [FILL_W-1:0] k_plus1;

  assign cur_slot    = slot_wrap(ring_head, scan_k);
  assign st.hit      = (slot_index[cur_slot] == idx_q);
  assign st.scan_end = (scan_k == ring_fill);
  assign st.pkt_ok   = (pkts_q == packets_per_part);

  assign ring_full = (ring_fill == FILL_W'(OPEN_FRAMES));
  // When full, the oldest slot is evicted and its place is reused at the tail.
  assign open_slot = ring_full ? ring_head : slot_wrap(ring_head, ring_fill);
  // The first origin part ever seen becomes the time origin, so its time is zero.
  assign rel_time  = origin_seen ? (ts_q - origin_time) : 64'd0;
  assign parts_inc = (slot_parts[cur_slot] == PARTS_MAX) ? PARTS_MAX
                                                        : slot_parts[cur_slot] + 4'd1;
  assign complete  = (parts_inc == parts_per_frame);
  assign add_time  = at_origin_q ? rel_time : slot_time[cur_slot];
  assign add_valid = at_origin_q | slot_time_valid[cur_slot];
  assign k_plus1   = scan_k + FILL_W'(1);

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head        <= '0;
      ring_fill        <= '0;
      scan_k           <= '0;
      origin_seen      <= 1'b0;
      parts_per_frame  <= PARTS_PER_FRAME_RST;
      packets_per_part <= PACKETS_PER_PART_RST;
      done             <= 1'b0;
    end else begin
      done <= cmd.do_reject | cmd.do_add | cmd.do_open;
      if (cfg_valid) begin
        case (cfg_index)
          REG_PARTS_PER_FRAME:  parts_per_frame  <= cfg_data[3:0];
          REG_PACKETS_PER_PART: packets_per_part <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        scan_k <= '0;
      end else if (cmd.step) begin
        scan_k <= k_plus1;
      end
      if ((cmd.do_add || cmd.do_open) && at_origin_q) begin
        origin_seen <= 1'b1;
      end
      if (cmd.do_add && complete) begin
        // The completed frame and every older open frame leave the ring.
        ring_head <= slot_wrap(ring_head, k_plus1);
        ring_fill <= ring_fill - k_plus1;
      end else if (cmd.do_open) begin
        if (ring_full) begin
          ring_head <= slot_wrap(ring_head, FILL_W'(1));
        end else begin
          ring_fill <= ring_fill + FILL_W'(1);
        end
      end
    end
  end

  // Input latches, slot storage, origin time and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q       <= frame_index;
      pkts_q      <= packet_count;
      at_origin_q <= (part_x == 3'd0) && (part_y == 3'd0);
      ts_q        <= part_timestamp;
    end
    if ((cmd.do_add || cmd.do_open) && at_origin_q && !origin_seen) begin
      origin_time <= ts_q;
    end
    if (cmd.do_add) begin
      slot_parts[cur_slot]      <= parts_inc;
      slot_time[cur_slot]       <= add_time;
      slot_time_valid[cur_slot] <= add_valid;
    end
    if (cmd.do_open) begin
      slot_index[open_slot]      <= idx_q;
      slot_parts[open_slot]      <= 4'd1;
      slot_time[open_slot]       <= at_origin_q ? rel_time : 64'd0;
      slot_time_valid[open_slot] <= at_origin_q;
    end

    done_index <= idx_q;
    if (cmd.do_reject) begin
      status           <= ST_REJECTED;
      purged_count     <= 5'd0;
      frame_time       <= 64'd0;
      frame_time_valid <= 1'b0;
    end else if (cmd.do_add) begin
      status           <= complete ? ST_COMPLETED : ST_ADDED;
      purged_count     <= complete ? purge_sat(scan_k) : 5'd0;
      frame_time       <= add_time;
      frame_time_valid <= add_valid;
    end else if (cmd.do_open) begin
      status           <= ring_full ? ST_OPEN_EVICT : ST_OPENED;
      purged_count     <= ring_full ? 5'd1 : 5'd0;
      frame_time       <= at_origin_q ? rel_time : 64'd0;
      frame_time_valid <= at_origin_q;
    end
  end

endmodule

// ===== design/frame_part_reassembly_tracker.sv =====
// Top level of the frame part reassembly tracker: controller plus datapath.
// Depends on frpt_pkg, frpt_ctrl and frpt_dp.
//
//   channel   signals                                            transfer when
//   part in   start, busy, frame_index .. part_timestamp         start && !busy
//   result    done, status, done_index .. frame_time_valid       done
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data          cfg_valid && cfg_ready
//
// An accepted part keeps busy high while the open slots are compared one per cycle,
// oldest first, and the update lands at the edge that ends the matching cycle or the
// cycle past the newest slot. A rejected part ends the scan before any slot is compared.
// The result strobe done is high for one cycle after busy falls; the receiver
// cannot stall it, and a new part may be started in that same cycle.
// Reset is synchronous; it empties the ring, forgets the time origin and
// restores the register defaults. cfg_ready is always high.
`timescale 1ns / 1ps

module frame_part_reassembly_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [63:0]                    frame_index,
  input  logic [15:0]                    packet_count,
  input  logic [2:0]                     part_x,
  input  logic [2:0]                     part_y,
  input  logic [63:0]                    part_timestamp,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [63:0]                    done_index,
  output logic [4:0]                     purged_count,
  output logic [63:0]                    frame_time,
  output logic                           frame_time_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import frpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  frpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  frpt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .frame_index      (frame_index),
    .packet_count     (packet_count),
    .part_x           (part_x),
    .part_y           (part_y),
    .part_timestamp   (part_timestamp),
    .done             (done),
    .status           (status),
    .done_index       (done_index),
    .purged_count     (purged_count),
    .frame_time       (frame_time),
    .frame_time_valid (frame_time_valid)
  );

endmodule

// ===== design/frpt_checker.sv =====
// Port-level checks of the frame part reassembly tracker, bound to the top level.
// Depends on frpt_pkg and frame_part_reassembly_tracker_defines.svh.
`timescale 1ns / 1ps
`include "frame_part_reassembly_tracker_defines.svh"

module frpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [4:0]  purged_count,
  input logic [63:0] frame_time,
  input logic        frame_time_valid
);
  import frpt_pkg::*;

  // A started part makes the block busy in the following cycle.
  `FPRT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // Every result follows a cycle in which the block was working.
  `FPRT_ASSERT_NOW(a_done_after_busy, done, $past(busy))
  `FPRT_ASSERT_NOW(a_status_range, done, status <= ST_OPEN_EVICT)
  // A rejected part carries no time.
  `FPRT_ASSERT_NOW(a_reject_clean, done && status == ST_REJECTED, !frame_time_valid && frame_time == '0)
  // Only completion and eviction purge older frames.
  `FPRT_ASSERT_NOW(a_no_purge_plain, done && status <= ST_ADDED, purged_count == 5'd0)

endmodule

bind frame_part_reassembly_tracker frpt_checker u_frpt_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench of frame_part_reassembly_tracker: directed parts, then phases
// of random frame sequences under several register settings, checked by a built-in tracker.
// Depends on frpt_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;
  import frpt_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_OPS     = 150;
  localparam int PHASE_ITEMS  = 115;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {OP_PART, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct packed {
    logic [63:0] index;
    logic [15:0] packets;
    logic [2:0]  x;
    logic [2:0]  y;
    logic [63:0] stamp;
  } part_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] index;
    logic [4:0]  purged;
    logic [63:0] ftime;
    logic        ftime_ok;
  } frame_result_t;

  typedef struct packed {
    op_kind_t              kind;
    part_t                 part;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [15:0]           reg_val;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [63:0] frame_index = '0;
  logic [15:0] packet_count = '0;
  logic [2:0] part_x = '0;
  logic [2:0] part_y = '0;
  logic [63:0] part_timestamp = '0;
  logic done;
  logic [2:0] status;
  logic [63:0] done_index;
  logic [4:0] purged_count;
  logic [63:0] frame_time;
  logic frame_time_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  frame_part_reassembly_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .frame_index(frame_index), .packet_count(packet_count), .part_x(part_x),
    .part_y(part_y), .part_timestamp(part_timestamp),
    .done(done), .status(status), .done_index(done_index), .purged_count(purged_count),
    .frame_time(frame_time), .frame_time_valid(frame_time_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Open frame tracker kept alongside the block.
  logic [63:0] trk_index [OPEN_FRAMES];
  logic [3:0]  trk_parts [OPEN_FRAMES];
  logic [63:0] trk_time [OPEN_FRAMES];
  logic        trk_time_ok [OPEN_FRAMES];
  int          trk_head = 0;
  int          trk_fill = 0;
  logic [63:0] origin_stamp = '0;
  logic        origin_known = 1'b0;
  logic [3:0]  cfg_parts = PARTS_PER_FRAME_RST;
  logic [15:0] cfg_packets = PACKETS_PER_PART_RST;

  frame_result_t awaited_results [$];
  op_t pending_ops [$];
  int mismatches = 0;
  int cycles = 0;

  // Stimulus generator state.
  logic [63:0] live_index [$];
  int live_parts [$];
  logic [3:0] gen_parts = PARTS_PER_FRAME_RST;
  logic [15:0] gen_packets = PACKETS_PER_PART_RST;

  function automatic frame_result_t track_part(input part_t p);
    frame_result_t r;
    int k;
    int hit;
    int s;
    r = '0;
    r.index = p.index;
    if (p.packets != cfg_packets) begin
      r.status = ST_REJECTED;
      return r;
    end
    hit = -1;
    for (k = 0; k < trk_fill; k++) begin
      if (hit < 0 && trk_index[(trk_head + k) % OPEN_FRAMES] == p.index) hit = k;
    end
    if (hit >= 0) begin
      s = (trk_head + hit) % OPEN_FRAMES;
      if (trk_parts[s] < PARTS_MAX) trk_parts[s] = trk_parts[s] + 4'd1;
      r.status = ST_ADDED;
    end else begin
      r.status = ST_OPENED;
      if (trk_fill >= OPEN_FRAMES) begin
        // The ring is full: the oldest open frame is dropped to make room.
        trk_head = (trk_head + 1) % OPEN_FRAMES;
        trk_fill--;
        r.status = ST_OPEN_EVICT;
        r.purged = 5'd1;
      end
      s = (trk_head + trk_fill) % OPEN_FRAMES;
      trk_fill++;
      trk_index[s] = p.index;
      trk_parts[s] = 4'd1;
      trk_time[s] = '0;
      trk_time_ok[s] = 1'b0;
    end
    if (p.x == 3'd0 && p.y == 3'd0) begin
      if (!origin_known) begin
        origin_stamp = p.stamp;
        origin_known = 1'b1;
      end
      trk_time[s] = p.stamp - origin_stamp;
      trk_time_ok[s] = 1'b1;
    end
    r.ftime = trk_time[s];
    r.ftime_ok = trk_time_ok[s];
    if (hit >= 0 && trk_parts[s] == cfg_parts) begin
      // Completion removes the frame and every older one still open.
      r.status = ST_COMPLETED;
      r.purged = (hit > 31) ? 5'd31 : 5'(hit);
      trk_head = (trk_head + hit + 1) % OPEN_FRAMES;
      trk_fill -= hit + 1;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  logic part_taken = 1'b0;
  logic cfg_taken = 1'b0;

  always @(posedge clk) begin
    frame_result_t want;
    part_t p;
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
    part_taken <= !rst && start && !busy;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          report("result with nothing awaited, index", done_index, '0);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (status != want.status) report("status", 64'(status), 64'(want.status));
          if (done_index != want.index) report("done_index", done_index, want.index);
          if (purged_count != want.purged) begin
            report("purged_count", 64'(purged_count), 64'(want.purged));
          end
          if (frame_time != want.ftime) report("frame_time", frame_time, want.ftime);
          if (frame_time_valid != want.ftime_ok) begin
            report("frame_time_valid", 64'(frame_time_valid), 64'(want.ftime_ok));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PARTS_PER_FRAME) cfg_parts = cfg_data[3:0];
        else if (cfg_index == REG_PACKETS_PER_PART) cfg_packets = cfg_data;
      end
      if (start && !busy) begin
        p.index = frame_index;
        p.packets = packet_count;
        p.x = part_x;
        p.y = part_y;
        p.stamp = part_timestamp;
        awaited_results.insert(awaited_results.size(), track_part(p));
      end
    end
  end

  // Driver: one pending operation at a time, with random idle bursts between them.
  op_t cur_op;
  logic op_live = 1'b0;
  logic drv_start;
  logic drv_cfg;
  logic finished;
  int gap_left = 0;
  int calm_left = 0;

  always @(negedge clk) begin
    if (!rst) begin
      drv_start = start;
      drv_cfg = cfg_valid;
      finished = 1'b0;
      if (start && part_taken) begin
        drv_start = 1'b0;
        finished = 1'b1;
      end
      if (cfg_valid && cfg_taken) begin
        drv_cfg = 1'b0;
        finished = 1'b1;
      end
      if (op_live && cur_op.kind == OP_DRAIN && awaited_results.size() == 0 && !busy) begin
        finished = 1'b1;
      end
      if (finished) begin
        op_live = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
        end else if (pending_ops.size() > TAIL_OPS) begin
          if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
          else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 18);
        end
      end
      if (!op_live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops[0];
          pending_ops.delete(0);
          op_live = 1'b1;
          case (cur_op.kind)
            OP_PART: begin
              drv_start = 1'b1;
              frame_index <= cur_op.part.index;
              packet_count <= cur_op.part.packets;
              part_x <= cur_op.part.x;
              part_y <= cur_op.part.y;
              part_timestamp <= cur_op.part.stamp;
            end
            OP_CFG: begin
              drv_cfg = 1'b1;
              cfg_index <= cur_op.reg_sel;
              cfg_data <= cur_op.reg_val;
            end
            default: ;
          endcase
        end
      end
      start <= drv_start;
      cfg_valid <= drv_cfg;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_part(input logic [63:0] idx, input logic [15:0] pkts,
                           input logic [2:0] px, input logic [2:0] py,
                           input logic [63:0] stamp);
    op_t op;
    op = '0;
    op.kind = OP_PART;
    op.part.index = idx;
    op.part.packets = pkts;
    op.part.x = px;
    op.part.y = py;
    op.part.stamp = stamp;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [15:0] val);
    op_t op;
    op = '0;
    op.kind = OP_CFG;
    op.reg_sel = sel;
    op.reg_val = val;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic push_drain();
    op_t op;
    op = '0;
    op.kind = OP_DRAIN;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // Writes both registers once the block is idle, then queues random frame traffic.
  task automatic run_phase(input logic [3:0] parts, input logic [15:0] pkts);
    int i;
    int j;
    int r;
    int target;
    logic [63:0] idx;
    logic [63:0] stamp;
    logic [15:0] pk;
    logic [2:0] px;
    logic [2:0] py;
    push_drain();
    push_cfg(REG_PARTS_PER_FRAME, {12'($urandom), parts});
    push_cfg(REG_PACKETS_PER_PART, pkts);
    gen_parts = parts;
    gen_packets = pkts;
    live_index.delete();
    live_parts.delete();
    // Frames that never complete collect parts until the counter saturates.
    target = (parts < 4'd2) ? 20 : int'(parts);
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 59) == 0) push_drain();
      px = 3'($urandom);
      py = 3'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        px = 3'd0;
        py = 3'd0;
      end
      case ($urandom_range(0, 7))
        0: stamp = '0;
        1: stamp = '1;
        default: stamp = rand64();
      endcase
      r = $urandom_range(0, 99);
      pk = gen_packets;
      if (r < 10) begin
        pk = 16'($urandom);
        if (pk == gen_packets) pk = ~pk;
        idx = (live_index.size() > 0) ? live_index[$urandom_range(0, live_index.size() - 1)]
                                      : rand64();
      end else if (r < 28 || live_index.size() == 0) begin
        idx = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 40)) : rand64();
        live_index.insert(live_index.size(), idx);
        live_parts.insert(live_parts.size(), 1);
        if (live_index.size() > 20) begin
          live_index.delete(0);
          live_parts.delete(0);
        end
      end else begin
        j = $urandom_range(0, live_index.size() - 1);
        idx = live_index[j];
        live_parts[j]++;
        if (live_parts[j] >= target) begin
          live_index.delete(j);
          live_parts.delete(j);
        end
      end
      push_part(idx, pk, px, py, stamp);
    end
  endtask

  initial begin
    int i;
    // Directed part at the reset settings: four parts of 256 packets make a frame.
    push_part(64'd0, 16'd256, 3'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFF0);
    push_part(64'd0, 16'd255, 3'd0, 3'd0, 64'd0);
    push_part(64'd0, 16'd0, 3'd7, 3'd7, 64'd0);
    push_part(64'd0, 16'hFFFF, 3'd0, 3'd0, 64'd1);
    push_part(64'd0, 16'd256, 3'd3, 3'd5, rand64());
    push_part(64'd0, 16'd256, 3'd7, 3'd7, rand64());
    // The completing part also sets the frame time, which wraps past zero.
    push_part(64'd0, 16'd256, 3'd0, 3'd0, 64'h10);
    push_part('1, 16'd256, 3'd0, 3'd0, 64'd5);
    for (i = 1; i <= 16; i++) begin
      push_part(64'h100 + 64'(i), 16'd256, 3'(i), 3'(i >> 3), rand64());
    end
    // Completing the newest frame purges all fifteen older ones.
    for (i = 0; i < 3; i++) begin
      push_part(64'h110, 16'd256, 3'd1, 3'd2, rand64());
    end
    push_drain();
    push_cfg(CFG_SPARE_A, 16'hFFFF);
    push_cfg(CFG_SPARE_B, 16'($urandom));
    run_phase(4'd2, 16'd0);
    run_phase(4'd8, 16'hFFFF);
    run_phase(4'd1, 16'($urandom));
    run_phase(4'd0, 16'($urandom));
    run_phase(4'd15, 16'($urandom));
    for (i = 0; i < 6; i++) begin
      run_phase(4'($urandom_range(2, 8)), 16'($urandom));
    end
    run_phase(PARTS_PER_FRAME_RST, PACKETS_PER_PART_RST);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || op_live || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
